>>> design/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Types and constants shared by the line substring filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

  localparam int MAX_LINE_DEF    = 1024;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int PAT_BYTES       = 16;
  localparam int LEN_W           = 11;
  localparam int PLEN_W          = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  localparam logic [7:0]       NEWLINE_BYTE = 8'd10;
  localparam logic [LEN_W-1:0] LEN_FIELD_MAX = '1;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOW    = 2'd1,
    CFG_PATTERN_HIGH   = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic             line_matched;
    logic [LEN_W-1:0] line_length;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic              empty;
    logic [PLEN_W-1:0] eff_len;
  } match_t;

endpackage

`default_nettype wire

>>> design/lsf_match.sv
// ----------------------------------------------------------------------------
// lsf_match
// Parallel compare of the byte window against the configured pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_match #(
  parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF
) (
  input  wire lsf_pkg::byte_t                     win [MAX_PATTERN],
  input  wire lsf_pkg::byte_t                     pat [lsf_pkg::PAT_BYTES],
  input  wire logic [lsf_pkg::PLEN_W-1:0]         plen,
  output lsf_pkg::match_t                         result
);
  import lsf_pkg::*;

  localparam logic [PLEN_W-1:0] MAX_PAT_L = PLEN_W'(MAX_PATTERN);

  logic [PLEN_W-1:0] limit;
  logic [PLEN_W-1:0] eff_len;
  logic              hit;
  logic              zero_found;
  logic [3:0]        pidx;

  // The pattern ends at its first zero byte within the used length.
  always_comb begin
    limit      = (plen > MAX_PAT_L) ? MAX_PAT_L : plen;
    eff_len    = limit;
    zero_found = 1'b0;
    for (int j = 0; j < PAT_BYTES; j++) begin
      if (!zero_found && (PLEN_W'(j) < limit) && (pat[j] == 8'd0)) begin
        eff_len    = PLEN_W'(j);
        zero_found = 1'b1;
      end
    end
  end

  // Window entry k holds the k-th newest byte and lines up with pattern
  // byte eff_len-1-k.
  always_comb begin
    hit  = 1'b1;
    pidx = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pidx = 4'(eff_len - PLEN_W'(1) - PLEN_W'(k));
      if ((PLEN_W'(k) < eff_len) && (win[k] != pat[pidx])) begin
        hit = 1'b0;
      end
    end
  end

  assign result.hit     = hit;
  assign result.empty   = (eff_len == '0);
  assign result.eff_len = eff_len;

endmodule

`default_nettype wire

>>> design/line_substring_filter_core.sv
// ----------------------------------------------------------------------------
// line_substring_filter_core
// Fixed-string line filter: one verdict and length per line of a byte stream.
// ----------------------------------------------------------------------------
// A line's verdict appears on the output register in the cycle after its newline
// beat (or an end-of-input beat that ends a non-empty line) is accepted.
// Throughput: one byte per cycle while in_stall is low; the window compare is done in that cycle.
// Reset clears the pattern registers, the line count and flags and the output valid.
`default_nettype none

module line_substring_filter_core #(
  parameter int MAX_LINE    = lsf_pkg::MAX_LINE_DEF,
  parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire lsf_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output lsf_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lsf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lsf_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE + 1);
  localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] MAX_LINE_C = CNT_W'(MAX_LINE);

  logic [PLEN_W-1:0]     plen_r;
  logic [CFG_DATA_W-1:0] plow_r;
  logic [CFG_DATA_W-1:0] phigh_r;

  byte_t            win_r   [MAX_PATTERN];
  byte_t            win_nxt [MAX_PATTERN];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             found_r, found_nxt;
  logic             zero_r, zero_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  byte_t            pat [PAT_BYTES];
  byte_t            win_shift [MAX_PATTERN];
  match_t           match;

  logic             in_acc;
  logic             eoi;
  byte_t            c;
  logic             do_store;
  logic             zs_new;
  logic             found_post;
  logic [CNT_W-1:0] count_post;
  logic [CNT_W:0]   count_inc;
  logic             emit;
  logic [EXT_W-1:0] count_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      plow_r  <= '0;
      phigh_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_LENGTH: plen_r  <= cfg_data[PLEN_W-1:0];
        CFG_PATTERN_LOW:    plow_r  <= cfg_data;
        CFG_PATTERN_HIGH:   phigh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      pat[j]     = plow_r[8*j +: 8];
      pat[j + 8] = phigh_r[8*j +: 8];
    end
  end

  assign c   = in_data.data_byte;
  assign eoi = in_data.end_of_input;

  always_comb begin
    win_shift[0] = c;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_shift[k] = win_r[k-1];
    end
  end

  lsf_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .win    (win_shift),
    .pat    (pat),
    .plen   (plen_r),
    .result (match)
  );

  always_comb begin
    do_store   = ~eoi && (count_r < MAX_LINE_C);
    zs_new     = zero_r | (c == 8'd0);
    count_inc  = {1'b0, count_r} + (CNT_W+1)'(1);
    count_post = do_store ? count_inc[CNT_W-1:0] : count_r;
    found_post = found_r;
    if (do_store && !zs_new) begin
      if (match.empty) begin
        if (count_r == '0) begin
          found_post = 1'b1;
        end
      end else if ((count_inc >= (CNT_W+1)'(match.eff_len)) && match.hit) begin
        found_post = 1'b1;
      end
    end
    emit      = eoi ? (count_r != '0) : (c == NEWLINE_BYTE);
    count_ext = EXT_W'(count_post);

    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k];
    end
    count_nxt = count_r;
    found_nxt = found_r;
    zero_nxt  = zero_r;
    if (in_acc) begin
      if (eoi || emit) begin
        count_nxt = '0;
        found_nxt = 1'b0;
        zero_nxt  = 1'b0;
      end else if (do_store) begin
        if (!zs_new) begin
          for (int k = 0; k < MAX_PATTERN; k++) begin
            win_nxt[k] = win_shift[k];
          end
        end
        count_nxt = count_post;
        found_nxt = found_post;
        zero_nxt  = zs_new;
      end
    end

    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (in_acc && emit) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.line_matched = found_post;
      out_data_nxt.line_length  = (count_ext > EXT_W'(LEN_FIELD_MAX)) ?
                                  LEN_FIELD_MAX : count_ext[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      found_r     <= 1'b0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

>>> dv/lsf_checker.sv
// ----------------------------------------------------------------------------
// lsf_checker
// Scoreboard for the line substring filter. It follows every register write
// and input beat, keeps its own copy of the line state, predicts the verdict
// of each finished line and compares it with the result beats of the block.
// ----------------------------------------------------------------------------
module lsf_checker
  import lsf_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    open_verdicts,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PLEN_W-1:0]     len_reg;
  logic [CFG_DATA_W-1:0] low_reg;
  logic [CFG_DATA_W-1:0] high_reg;
  byte_t                 window [PAT_BYTES];
  int                    stored;
  logic                  found;
  logic                  after_zero;
  out_item_t             verdicts [$];
  int                    fails = 0;

  assign fail_count = fails;

  task automatic report_mismatch(input string what);
    if (fails < 50) $display("%0t ns checker: %s", $time, what);
    fails++;
  endtask

  function automatic byte_t pat_at(input int j);
    if (j < 8) return low_reg[8*j +: 8];
    return high_reg[8*(j-8) +: 8];
  endfunction

  function automatic int used_len();
    int lim;
    lim = (len_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(len_reg);
    for (int j = 0; j < lim; j++)
      if (pat_at(j) == 8'd0) return j;
    return lim;
  endfunction

  function automatic void clear_line();
    foreach (window[k]) window[k] = '0;
    stored     = 0;
    found      = 1'b0;
    after_zero = 1'b0;
  endfunction

  function automatic void close_line();
    out_item_t v;
    v.line_matched = found;
    v.line_length  = (stored > LEN_FIELD_MAX) ? LEN_FIELD_MAX : LEN_W'(stored);
    verdicts.push_back(v);
    clear_line();
  endfunction

  function automatic void take_beat(input in_item_t beat);
    int   n;
    logic hit;
    if (beat.end_of_input) begin
      if (stored > 0) close_line();
      else clear_line();
      return;
    end
    if (stored < MAX_LINE) begin
      if (beat.data_byte == 8'd0) after_zero = 1'b1;
      if (!after_zero) begin
        for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = beat.data_byte;
        n = used_len();
        if (n == 0) begin
          if (stored == 0) found = 1'b1;
        end else if (stored + 1 >= n) begin
          hit = 1'b1;
          for (int k = 0; k < n; k++)
            if (window[k] != pat_at(n - 1 - k)) hit = 1'b0;
          if (hit) found = 1'b1;
        end
      end
      stored++;
    end
    if (beat.data_byte == NEWLINE_BYTE) close_line();
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      len_reg  = '0;
      low_reg  = '0;
      high_reg = '0;
      clear_line();
      verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PATTERN_LENGTH: len_reg  = cfg_data[PLEN_W-1:0];
          CFG_PATTERN_LOW:    low_reg  = cfg_data;
          CFG_PATTERN_HIGH:   high_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected verdict matched=%0b length=%0d",
                                    out_data.line_matched, out_data.line_length));
        end else begin
          want = verdicts.pop_front();
          if (out_data.line_matched !== want.line_matched)
            report_mismatch($sformatf("line_matched got %0b want %0b",
                                      out_data.line_matched, want.line_matched));
          if (out_data.line_length !== want.line_length)
            report_mismatch($sformatf("line_length got %0d want %0d",
                                      out_data.line_length, want.line_length));
        end
      end
      if (in_valid && !in_stall) take_beat(in_data);
    end
    open_verdicts <= verdicts.size();
  end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the line substring filter with directed lines and then random text
// under three idle and stall mixes, reprogramming the pattern between bursts.
// The checker beside the block predicts and compares every line verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsf_pkg::*;

  localparam int    QUIET_LIMIT = 4000;
  localparam int    BEAT_TARGET = 1850;
  localparam byte_t LETTER_A    = 8'h61;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    open_verdicts;
  int                    fail_count;

  int    feed_idle_pct   = 24;
  int    drain_stall_pct = 85;
  int    beats_sent      = 0;
  int    quiet_cycles    = 0;
  byte_t pat_word [PAT_BYTES];
  int    plant_len       = 0;

  line_substring_filter_core DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  lsf_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .open_verdicts, .fail_count
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < drain_stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_beat(input byte_t b, input logic eoi);
    while ($urandom_range(99) < feed_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_input: eoi};
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(byte_t'(s[i]), 1'b0);
  endtask

  function automatic byte_t text_byte();
    if ($urandom_range(99) < 85) return byte_t'(LETTER_A + $urandom_range(2));
    return byte_t'($urandom_range(255));
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic program_pattern(input logic [CFG_DATA_W-1:0] len_word,
                                 input logic [CFG_DATA_W-1:0] lo,
                                 input logic [CFG_DATA_W-1:0] hi);
    logic [2*CFG_DATA_W-1:0] both;
    int                      lim;
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    write_reg(CFG_PATTERN_LENGTH, len_word);
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    cfg_valid <= 1'b0;
    both = {hi, lo};
    for (int j = 0; j < PAT_BYTES; j++) pat_word[j] = both[8*j +: 8];
    lim = (len_word[PLEN_W-1:0] > PAT_BYTES) ? PAT_BYTES : int'(len_word[PLEN_W-1:0]);
    plant_len = 0;
    while (plant_len < lim && pat_word[plant_len] != 8'd0) plant_len++;
  endtask

  task automatic program_random_pattern();
    logic [CFG_DATA_W-1:0]   len_word;
    logic [2*CFG_DATA_W-1:0] bytes_word;
    int                      roll;
    case ($urandom_range(9))
      0: len_word = '0;
      1: len_word = CFG_DATA_W'(1);
      2: len_word = CFG_DATA_W'(PAT_BYTES);
      3: begin
        len_word = {$urandom, $urandom};
        len_word[PLEN_W-1:0] = PLEN_W'($urandom_range(17, 31));
      end
      default: len_word = CFG_DATA_W'($urandom_range(2, 6));
    endcase
    for (int k = 0; k < 2 * PAT_BYTES; k++) begin
      roll = $urandom_range(99);
      if (roll < 85)      bytes_word[8*k +: 8] = byte_t'(LETTER_A + $urandom_range(2));
      else if (roll < 95) bytes_word[8*k +: 8] = byte_t'($urandom_range(1, 255));
      else if (roll < 98) bytes_word[8*k +: 8] = NEWLINE_BYTE;
      else                bytes_word[8*k +: 8] = 8'd0;
    end
    program_pattern(len_word, bytes_word[CFG_DATA_W-1:0],
                    bytes_word[2*CFG_DATA_W-1:CFG_DATA_W]);
  endtask

  task automatic send_line(input bit noisy);
    int body;
    int at;
    body = $urandom_range(24);
    at = (!noisy && plant_len > 0 && $urandom_range(1) == 1) ? $urandom_range(body) : -1;
    for (int i = 0; i <= body; i++) begin
      if (i == at)
        for (int j = 0; j < plant_len; j++) send_beat(pat_word[j], 1'b0);
      if (i < body)
        send_beat(noisy ? text_byte() : byte_t'(LETTER_A + $urandom_range(2)), 1'b0);
    end
    if (!noisy || $urandom_range(3) == 0) send_beat(NEWLINE_BYTE, 1'b0);
    else if ($urandom_range(1) == 0) send_beat(byte_t'($urandom_range(255)), 1'b1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_verdicts != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_random(input int feed_pct, input int drain_pct, input int beat_goal);
    feed_idle_pct   = feed_pct;
    drain_stall_pct = drain_pct;
    while (beats_sent < beat_goal) begin
      settle();
      program_random_pattern();
      repeat ($urandom_range(4, 16)) begin
        send_line($urandom_range(99) < 20);
        if ($urandom_range(99) < 4) send_beat(byte_t'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty pattern: a line matches unless its first byte is zero.
    program_pattern(64'd0, '1, '1);
    send_text("\n");
    send_beat(8'h00, 1'b0);
    send_text("\n");
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    settle();

    program_pattern(64'd2, 64'h6261, 64'd0);
    send_text("ab\n");
    send_text("a");
    send_beat(8'h00, 1'b0);
    send_text("b\n");
    settle();

    // Oversized length with a zero byte cutting the pattern to three bytes.
    program_pattern('1, 64'hFFFF_FFFF_0063_6261, '1);
    send_text("xabc\n");
    settle();

    program_pattern(64'd2, {48'd0, NEWLINE_BYTE, 8'h62}, 64'd0);
    send_text("ab\n");

    run_random(24, 85, 300);
    run_random(85, 24, 600);

    // An overlong line whose pattern ends on or just past the last stored byte.
    settle();
    program_pattern(64'd3, 64'h63_6261, 64'd0);
    repeat (MAX_LINE_DEF - 3 + $urandom_range(1))
      send_beat(byte_t'(8'h64 + $urandom_range(1)), 1'b0);
    send_text("abcabc\n");

    run_random(0, 0, BEAT_TARGET);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
design/lsf_pkg.sv
design/lsf_match.sv
design/line_substring_filter_core.sv
dv/lsf_checker.sv
dv/tb_top.sv
